FILE: design/khr_pkg.sv
// Shared types and constants for the key matrix to HID report encoder.
// No dependencies.
`default_nettype none

package khr_pkg;

   localparam int NUM_GROUPS     = 7;
   localparam int REPORT_KEYS    = 6;
   localparam int KEYS_PER_GROUP = 8;
   localparam int KEY_COUNT      = NUM_GROUPS * KEYS_PER_GROUP;
   localparam int MOD_ENTRIES    = 8;
   localparam int NUM_TABLES     = 3;
   localparam int TBL_DEPTH      = NUM_TABLES * KEYS_PER_GROUP;
   localparam int TBL_ADDR_W     = $clog2(TBL_DEPTH);
   localparam int LANE_W         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int CNT_W          = $clog2(REPORT_KEYS + 1);
   localparam int SLOT_W         = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;
   localparam int WALK_W         = $clog2(KEYS_PER_GROUP + 1);
   localparam int CSR_ADDR_W     = 3;

   localparam logic [7:0] UNUSED_MOD = 8'hFF;

   // action codes
   localparam logic ACT_SCAN = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   // table_select codes
   localparam logic [1:0] SEL_BASE   = 2'd0;
   localparam logic [1:0] SEL_SECOND = 2'd1;
   localparam logic [1:0] SEL_ALPHA  = 2'd2;
   localparam logic [1:0] SEL_MOD    = 2'd3;

   // register indexes
   localparam logic REG_ALPHA  = 1'b0;
   localparam logic REG_SECOND = 1'b1;

   typedef struct packed {
      logic       action;
      logic [1:0] table_select;
      logic [5:0] table_index;
      logic [7:0] table_value;
      logic [7:0] key_group_one;
      logic [7:0] key_group_two;
      logic [7:0] key_group_three;
      logic [7:0] key_group_four;
      logic [7:0] key_group_five;
      logic [7:0] key_group_six;
      logic [7:0] key_group_seven;
   } req_item_type;

   typedef struct packed {
      logic [7:0] modifier_bits;
      logic [7:0] keycode_one;
      logic [7:0] keycode_two;
      logic [7:0] keycode_three;
      logic [7:0] keycode_four;
      logic [7:0] keycode_five;
      logic [7:0] keycode_six;
   } rsp_item_type;

   // walk control broadcast to every lane
   typedef struct packed {
      logic                  clear;
      logic [TBL_ADDR_W-1:0] rd_addr;
      logic                  acc;
      logic [2:0]            acc_pos;
   } lane_ctrl_type;

   typedef struct packed {
      logic                  en;
      logic [TBL_ADDR_W-1:0] addr;
      logic [7:0]            data;
   } lane_wr_type;

   typedef struct packed {
      logic [REPORT_KEYS-1:0][7:0] codes;
      logic [CNT_W-1:0]            count;
   } lane_result_type;

   typedef struct packed {
      logic clear;
      logic take;
   } merge_ctrl_type;

endpackage

`default_nettype wire

FILE: design/khr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module khr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/khr_lane.sv
// One key-group lane: the group's slice of all three code tables and the
// compactor that gathers its pressed, nonzero codes. Uses khr_pkg, khr_ram.
`default_nettype none

module khr_lane
   import khr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lane_ctrl_type   ctrl,
   input  wire lane_wr_type     wr,
   input  wire logic [7:0]      key_bits,
   output lane_result_type      result
);

   logic [7:0]                  rd_data;
   logic [REPORT_KEYS-1:0][7:0] codes_ff, codes_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;

   khr_ram #(
      .WIDTH (8),
      .DEPTH (TBL_DEPTH)
   ) u_codes (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (ctrl.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      codes_in = codes_ff;
      cnt_in   = cnt_ff;
      if (ctrl.clear) begin
         cnt_in = '0;
      end else if (ctrl.acc && key_bits[ctrl.acc_pos] && (rd_data != 8'h00) &&
                   (cnt_ff < CNT_W'(REPORT_KEYS))) begin
         codes_in[cnt_ff[SLOT_W-1:0]] = rd_data;
         cnt_in                       = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      codes_ff <= codes_in;
   end

   assign result.codes = codes_ff;
   assign result.count = cnt_ff;

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(REPORT_KEYS))
      else $error("lane count past report size");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (cnt_ff == '0))
      else $error("lane not emptied by clear");

   a_acc_grows_by_one: assert property (@(posedge clock) disable iff (reset)
      !ctrl.clear |=> (cnt_ff == $past(cnt_ff)) || (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("lane count jumped");

endmodule

`default_nettype wire

FILE: design/khr_merge.sv
// Merging stage: appends each lane's codes, in lane order, to the report
// slots until they are full. Uses khr_pkg.
`default_nettype none

module khr_merge
   import khr_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire merge_ctrl_type              ctrl,
   input  wire lane_result_type             lane,
   output logic [REPORT_KEYS-1:0][7:0]      slots
);

   logic [REPORT_KEYS-1:0][7:0] rep_ff, rep_in;
   logic [CNT_W-1:0]            slot_ff, slot_in;

   always_comb begin
      logic [CNT_W:0] off;
      logic [CNT_W:0] sum;
      rep_in  = rep_ff;
      slot_in = slot_ff;
      off     = '0;
      sum     = '0;
      if (ctrl.clear) begin
         rep_in  = '0;
         slot_in = '0;
      end else if (ctrl.take) begin
         for (int s = 0; s < REPORT_KEYS; s++) begin
            off = (CNT_W + 1)'(s) - {1'b0, slot_ff};
            if (((CNT_W + 1)'(s) >= {1'b0, slot_ff}) && (off < {1'b0, lane.count})) begin
               rep_in[s] = lane.codes[off[SLOT_W-1:0]];
            end
         end
         sum = {1'b0, slot_ff} + {1'b0, lane.count};
         slot_in = (sum > (CNT_W + 1)'(REPORT_KEYS)) ? CNT_W'(REPORT_KEYS) : sum[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
      rep_ff <= rep_in;
   end

   assign slots = rep_ff;

   a_slot_bounded: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= CNT_W'(REPORT_KEYS))
      else $error("merge slot past report size");

   a_slot_monotonic: assert property (@(posedge clock) disable iff (reset)
      !ctrl.clear |=> slot_ff >= $past(slot_ff))
      else $error("merge slot went backwards");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (slot_ff == '0) && (rep_ff == '0))
      else $error("merge not cleared");

endmodule

`default_nettype wire

FILE: design/key_matrix_to_hid_report_unit.sv
// Top level of the key matrix to HID boot-keyboard report encoder.
// Uses khr_pkg, khr_lane, khr_merge (khr_ram inside each lane).
//
// Usage:
//  - req channel (req_valid/req_stall/req_data): one transaction is either a
//    table load (action = load) or a matrix scan of seven 8-bit key groups.
//  - rsp channel (rsp_valid/rsp_stall/rsp_data): a report transaction goes out
//    only when a scan gives a report that differs from the last one sent.
//  - csr_* APB port: alpha key index at 0x0, second key index at 0x4.
//    pready is tied high; write only while the block is idle.
// Timing:
//  - A load leaves the block idle; the next transaction can be taken straight away.
//  - A scan is accepted, then walks the seven lanes' table RAMs (8 keys,
//    one read per cycle, plus the registered read), merges the lanes (one
//    lane per cycle), then compares and emits; no request is taken meanwhile.
//    The lane walk and the lane-by-lane merge set the length of a scan.
// Stall: the result sits in an output register. A new scan may proceed
//  while it waits; only when the next report is ready does the block hold
//  in its emit step until the receiver takes the earlier one.
// Reset: synchronous; the modifier map reads all unused, key indexes go to
//  15 (alpha) and 5 (second), and the first scan always emits. Code tables
//  are not cleared and must be loaded before use.
`default_nettype none

module key_matrix_to_hid_report_unit
   import khr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_item_type          req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_item_type               rsp_data,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WALK  = 4'b0010,
      S_MERGE = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic [5:0] alpha_idx_ff, alpha_idx_in;
   logic [5:0] second_idx_ff, second_idx_in;
   logic       csr_wr;

   // scan context
   logic [KEY_COUNT-1:0] keys_ff, keys_in, req_keys;
   logic [1:0]           tsel_ff, tsel_in;
   logic [WALK_W-1:0]    walk_ff, walk_in;
   logic [LANE_W-1:0]    lane_ff, lane_in;

   // modifier map
   logic [7:0] mod_ff [MOD_ENTRIES];
   logic [7:0] mod_in [MOD_ENTRIES];

   // last report and output register
   rsp_item_type last_ff, last_in;
   logic         last_valid_ff, last_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic req_accept, scan_accept, load_accept;
   logic [1:0] scan_sel;

   lane_ctrl_type               lane_ctrl;
   lane_wr_type                 lane_wr [NUM_GROUPS];
   lane_result_type             lane_res [NUM_GROUPS];
   merge_ctrl_type              merge_ctrl;
   logic [REPORT_KEYS-1:0][7:0] slots;
   logic [5:0][7:0]             full_slots;
   logic [7:0]                  mod_bits;
   rsp_item_type                report;
   logic                        differs, out_free, emit;

   function automatic logic key_down(input logic [KEY_COUNT-1:0] keys,
                                     input logic [7:0] key);
      logic [63:0] pad;
      pad = 64'(keys);
      return (key < 8'(KEY_COUNT)) && pad[key[5:0]];
   endfunction

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      alpha_idx_in  = alpha_idx_ff;
      second_idx_in = second_idx_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_ALPHA:  alpha_idx_in  = csr_pwdata[5:0];
            REG_SECOND: second_idx_in = csr_pwdata[5:0];
            default:    alpha_idx_in  = alpha_idx_ff;
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SECOND) ? {26'd0, second_idx_ff}
                                                     : {26'd0, alpha_idx_ff};

   // ---------------- request side ----------------
   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign scan_accept = req_accept && (req_data.action == ACT_SCAN);
   assign load_accept = req_accept && (req_data.action == ACT_LOAD);

   // key k is bit k of the flattened matrix
   assign req_keys = {req_data.key_group_seven, req_data.key_group_six,
                      req_data.key_group_five,  req_data.key_group_four,
                      req_data.key_group_three, req_data.key_group_two,
                      req_data.key_group_one};

   // table choice: alpha beats second beats base
   always_comb begin
      if (key_down(req_keys, {2'b00, alpha_idx_ff})) begin
         scan_sel = SEL_ALPHA;
      end else if (key_down(req_keys, {2'b00, second_idx_ff})) begin
         scan_sel = SEL_SECOND;
      end else begin
         scan_sel = SEL_BASE;
      end
   end

   // modifier map loads
   always_comb begin
      for (int b = 0; b < MOD_ENTRIES; b++) begin
         mod_in[b] = mod_ff[b];
      end
      if (load_accept && (req_data.table_select == SEL_MOD) &&
          (req_data.table_index < 6'(MOD_ENTRIES))) begin
         mod_in[req_data.table_index[2:0]] = req_data.table_value;
      end
   end

   // ---------------- lanes ----------------
   assign lane_ctrl.clear   = scan_accept;
   assign lane_ctrl.rd_addr = {tsel_ff, walk_ff[2:0]};
   assign lane_ctrl.acc     = (state_ff == S_WALK) && (walk_ff != '0);
   assign lane_ctrl.acc_pos = walk_ff[2:0] - 3'd1;

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_lane
      assign lane_wr[g].en   = load_accept && (req_data.table_select != SEL_MOD) &&
                               (req_data.table_index < 6'(KEY_COUNT)) &&
                               (req_data.table_index[5:3] == 3'(g));
      assign lane_wr[g].addr = {req_data.table_select, req_data.table_index[2:0]};
      assign lane_wr[g].data = req_data.table_value;

      khr_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .wr       (lane_wr[g]),
         .key_bits (keys_ff[g*KEYS_PER_GROUP +: KEYS_PER_GROUP]),
         .result   (lane_res[g])
      );
   end

   // ---------------- merge ----------------
   assign merge_ctrl.clear = scan_accept;
   assign merge_ctrl.take  = (state_ff == S_MERGE);

   khr_merge u_merge (
      .clock (clock),
      .reset (reset),
      .ctrl  (merge_ctrl),
      .lane  (lane_res[lane_ff]),
      .slots (slots)
   );

   // ---------------- report build and compare ----------------
   always_comb begin
      for (int b = 0; b < MOD_ENTRIES; b++) begin
         mod_bits[b] = (mod_ff[b] != UNUSED_MOD) && key_down(keys_ff, mod_ff[b]);
      end
   end

   assign full_slots           = (6 * 8)'(slots);
   assign report.modifier_bits = mod_bits;
   assign report.keycode_one   = full_slots[0];
   assign report.keycode_two   = full_slots[1];
   assign report.keycode_three = full_slots[2];
   assign report.keycode_four  = full_slots[3];
   assign report.keycode_five  = full_slots[4];
   assign report.keycode_six   = full_slots[5];

   assign differs  = !last_valid_ff || (report != last_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (state_ff == S_EMIT) && differs && out_free;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      keys_in  = keys_ff;
      tsel_in  = tsel_ff;
      walk_in  = walk_ff;
      lane_in  = lane_ff;
      case (state_ff)
         S_IDLE: begin
            if (scan_accept) begin
               keys_in  = req_keys;
               tsel_in  = scan_sel;
               walk_in  = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // reads issue on 0..7; each is accumulated in the cycle after its read
            if (walk_ff == WALK_W'(KEYS_PER_GROUP)) begin
               lane_in  = '0;
               state_in = S_MERGE;
            end else begin
               walk_in = walk_ff + WALK_W'(1);
            end
         end
         S_MERGE: begin
            if (lane_ff == LANE_W'(NUM_GROUPS - 1)) begin
               state_in = S_EMIT;
            end else begin
               lane_in = lane_ff + LANE_W'(1);
            end
         end
         S_EMIT: begin
            if (!differs || out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      last_in       = last_ff;
      last_valid_in = last_valid_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = report;
         last_in       = report;
         last_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         alpha_idx_ff  <= 6'd15;
         second_idx_ff <= 6'd5;
         rsp_valid_ff  <= 1'b0;
         last_valid_ff <= 1'b0;
         walk_ff       <= '0;
         lane_ff       <= '0;
         for (int b = 0; b < MOD_ENTRIES; b++) begin
            mod_ff[b] <= UNUSED_MOD;
         end
      end else begin
         state_ff      <= state_in;
         alpha_idx_ff  <= alpha_idx_in;
         second_idx_ff <= second_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_valid_ff <= last_valid_in;
         walk_ff       <= walk_in;
         lane_ff       <= lane_in;
         for (int b = 0; b < MOD_ENTRIES; b++) begin
            mod_ff[b] <= mod_in[b];
         end
      end
      keys_ff     <= keys_in;
      tsel_ff     <= tsel_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_emit_marks_last: assert property (@(posedge clock) disable iff (reset)
      emit |=> last_valid_ff && (last_ff == rsp_data_ff) && rsp_valid_ff)
      else $error("emitted report not recorded as last sent");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      load_accept |=> (state_ff == S_IDLE))
      else $error("load transaction left idle");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (walk_ff <= WALK_W'(KEYS_PER_GROUP)))
      else $error("walk counter overran the group");

   a_scan_no_early_result: assert property (@(posedge clock) disable iff (reset)
      scan_accept |=> !emit)
      else $error("result emitted before the walk");

endmodule

`default_nettype wire

FILE: test/key_matrix_to_hid_report_unit_tb.sv
// Self-checking testbench for the key matrix to HID report encoder.
// Depends on khr_pkg and key_matrix_to_hid_report_unit; predicts each report
// from the accepted transactions and checks the result channel against it.

module key_matrix_to_hid_report_unit_tb;
   import khr_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 40;    // longer than a whole scan takes
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 135;
   localparam logic [KEY_COUNT-1:0] ONE_KEY = KEY_COUNT'(1);

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_item_type          req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predictor copy of the block's state
   logic [7:0]   base_tbl     [KEY_COUNT];
   logic [7:0]   second_tbl   [KEY_COUNT];
   logic [7:0]   alpha_tbl    [KEY_COUNT];
   logic [7:0]   mod_key_map  [MOD_ENTRIES];
   rsp_item_type sent_report  = '1;
   bit           sent_once    = 1'b0;
   logic [5:0]   alpha_key    = 6'd15;
   logic [5:0]   second_key   = 6'd5;

   rsp_item_type         expected_reports [$];
   logic [KEY_COUNT-1:0] last_keys     = '0;
   int                   mismatches    = 0;
   int                   cycle_count   = 0;
   int                   send_gap_pct  = 20;   // chance of a gap before a transaction
   int                   stall_pct     = 10;   // chance per cycle of a stall burst
   int                   stall_left    = 0;

   key_matrix_to_hid_report_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   initial begin
      for (int b = 0; b < MOD_ENTRIES; b++) mod_key_map[b] = UNUSED_MOD;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver back-pressure: stall bursts of random length
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, exp_v, act_v);
   endfunction

   // Every report transaction taken is checked, field by field, against the oldest prediction
   always @(posedge clock) begin : check_reports
      rsp_item_type exp_rep;
      bit           bad;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_reports.size() == 0) begin
            note_mismatch("unexpected report", 64'h0, 64'(rsp_data));
         end else begin
            exp_rep = expected_reports.pop_front();
            bad = 1'b0;
            for (int f = 0; f < $bits(rsp_item_type); f += 8)
               if (exp_rep[f +: 8] !== rsp_data[f +: 8]) bad = 1'b1;
            if (bad) note_mismatch("report", 64'(exp_rep), 64'(rsp_data));
         end
      end
   end

   function automatic bit key_pressed(logic [KEY_COUNT-1:0] keys, logic [7:0] k);
      if (k >= KEY_COUNT) return 1'b0;
      return keys[k];
   endfunction

   // Predictor: applies one accepted transaction and queues the report it causes, if any
   task automatic predict_report(req_item_type it);
      logic [KEY_COUNT-1:0] keys;
      logic [1:0]           chosen;
      logic [7:0]           code;
      logic [7:0]           mods;
      logic [7:0]           slots [REPORT_KEYS];
      int                   filled;
      rsp_item_type         rep;
      if (it.action == ACT_LOAD) begin
         if (it.table_select == SEL_MOD) begin
            if (it.table_index < MOD_ENTRIES)
               mod_key_map[it.table_index[2:0]] = it.table_value;
         end else if (it.table_index < KEY_COUNT) begin
            case (it.table_select)
               SEL_BASE:   base_tbl[it.table_index]   = it.table_value;
               SEL_SECOND: second_tbl[it.table_index] = it.table_value;
               default:    alpha_tbl[it.table_index]  = it.table_value;
            endcase
         end
      end else begin
         keys = {it.key_group_seven, it.key_group_six, it.key_group_five, it.key_group_four,
                 it.key_group_three, it.key_group_two, it.key_group_one};
         if (key_pressed(keys, {2'b00, alpha_key}))
            chosen = SEL_ALPHA;
         else if (key_pressed(keys, {2'b00, second_key}))
            chosen = SEL_SECOND;
         else
            chosen = SEL_BASE;
         filled = 0;
         mods   = '0;
         foreach (slots[s]) slots[s] = '0;
         // keys walked in index order; codes past the sixth are dropped
         for (int k = 0; k < KEY_COUNT; k++) begin
            if (filled < REPORT_KEYS && keys[k]) begin
               case (chosen)
                  SEL_ALPHA:  code = alpha_tbl[k];
                  SEL_SECOND: code = second_tbl[k];
                  default:    code = base_tbl[k];
               endcase
               if (code != 8'h00) begin
                  slots[filled] = code;
                  filled++;
               end
            end
         end
         for (int b = 0; b < MOD_ENTRIES; b++)
            if (mod_key_map[b] != UNUSED_MOD && key_pressed(keys, mod_key_map[b]))
               mods[b] = 1'b1;
         rep.modifier_bits = mods;
         rep.keycode_one   = slots[0];
         rep.keycode_two   = slots[1];
         rep.keycode_three = slots[2];
         rep.keycode_four  = slots[3];
         rep.keycode_five  = slots[4];
         rep.keycode_six   = slots[5];
         // first scan after reset always goes out; later ones only on change
         if (!sent_once || rep != sent_report) begin
            sent_report = rep;
            sent_once   = 1'b1;
            expected_reports.push_back(rep);
         end
      end
   endtask

   // Sends one transaction; returns at the edge where it was accepted
   task automatic send_item(req_item_type it);
      int gap;
      @(negedge clock);
      gap = 0;
      if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) gap = $urandom_range(1, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_report(it);
   endtask

   // Drops valid, waits for every report, then lets a scan with no report finish
   task automatic wait_idle;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == REG_ALPHA) alpha_key = data[5:0];
      else second_key = data[5:0];
   endtask

   task automatic csr_check(logic reg_sel, logic [5:0] exp_v);
      logic [31:0] rd;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd[5:0] !== exp_v) note_mismatch("register read", 64'(exp_v), 64'(rd));
   endtask

   // Upper write-data bits are junk on purpose: only six bits are kept
   task automatic set_key_indexes(logic [5:0] alpha_v, logic [5:0] second_v);
      csr_write(REG_ALPHA, {26'($urandom), alpha_v});
      csr_write(REG_SECOND, {26'($urandom), second_v});
      csr_check(REG_ALPHA, alpha_v);
      csr_check(REG_SECOND, second_v);
   endtask

   // Load transaction; key groups carry junk, which the block ignores
   function automatic req_item_type load_item(logic [1:0] sel, logic [5:0] idx, logic [7:0] val);
      req_item_type it;
      logic [63:0]  r;
      r = {$urandom, $urandom};
      it.action       = ACT_LOAD;
      it.table_select = sel;
      it.table_index  = idx;
      it.table_value  = val;
      {it.key_group_seven, it.key_group_six, it.key_group_five, it.key_group_four,
       it.key_group_three, it.key_group_two, it.key_group_one} = r[KEY_COUNT-1:0];
      return it;
   endfunction

   // Scan transaction; table fields carry junk, which the block ignores
   function automatic req_item_type scan_item(logic [KEY_COUNT-1:0] keys);
      req_item_type it;
      it.action       = ACT_SCAN;
      it.table_select = 2'($urandom_range(0, 3));
      it.table_index  = 6'($urandom_range(0, 63));
      it.table_value  = 8'($urandom);
      {it.key_group_seven, it.key_group_six, it.key_group_five, it.key_group_four,
       it.key_group_three, it.key_group_two, it.key_group_one} = keys;
      return it;
   endfunction

   // Table loads and mostly plausible keyboard scans: a few keys, repeats, single changes
   function automatic req_item_type random_item();
      logic [63:0]          r;
      logic [KEY_COUNT-1:0] keys;
      int                   pick;
      logic [1:0]           sel;
      logic [5:0]           idx;
      logic [7:0]           val;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         sel = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) idx = 6'($urandom_range(0, 63));
         else if (sel == SEL_MOD) idx = 6'($urandom_range(0, MOD_ENTRIES - 1));
         else idx = 6'($urandom_range(0, KEY_COUNT - 1));
         if (sel == SEL_MOD) begin
            case ($urandom_range(0, 6))
               0:       val = UNUSED_MOD;
               1:       val = 8'($urandom);
               default: val = 8'($urandom_range(0, KEY_COUNT - 1));
            endcase
         end else begin
            val = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
         end
         return load_item(sel, idx, val);
      end
      pick = $urandom_range(0, 99);
      r = {$urandom, $urandom};
      if (pick < 35) begin
         keys = '0;
         repeat ($urandom_range(1, 8)) keys[$urandom_range(0, KEY_COUNT - 1)] = 1'b1;
         if ($urandom_range(0, 3) == 0 && alpha_key < KEY_COUNT) keys[alpha_key] = 1'b1;
         if ($urandom_range(0, 3) == 0 && second_key < KEY_COUNT) keys[second_key] = 1'b1;
      end else if (pick < 55) begin
         keys = last_keys;
      end else if (pick < 70) begin
         keys = last_keys;
         keys[$urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
      end else if (pick < 88) begin
         keys = r[KEY_COUNT-1:0];
      end else if (pick < 94) begin
         keys = '1;
      end else begin
         keys = '0;
      end
      last_keys = keys;
      return scan_item(keys);
   endfunction

   task automatic fill_code_table(logic [1:0] sel);
      for (int k = 0; k < KEY_COUNT; k++)
         send_item(load_item(sel, 6'(k),
                             ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255))));
   endtask

   task automatic test_reset_values;
      csr_check(REG_ALPHA, 6'd15);
      csr_check(REG_SECOND, 6'd5);
   endtask

   // Report of all ones equals the reset value of the last report, yet must go out
   task automatic test_first_report;
      fill_code_table(SEL_BASE);
      fill_code_table(SEL_SECOND);
      fill_code_table(SEL_ALPHA);
      for (int k = 40; k < 48; k++) send_item(load_item(SEL_BASE, 6'(k), 8'h00));
      for (int k = 48; k < 54; k++) send_item(load_item(SEL_BASE, 6'(k), 8'hFF));
      for (int b = 0; b < MOD_ENTRIES; b++)
         send_item(load_item(SEL_MOD, 6'(b), 8'(40 + b)));
      send_item(scan_item(((ONE_KEY << 14) - ONE_KEY) << 40));
   endtask

   task automatic test_repeat_suppressed;
      send_item(scan_item(((ONE_KEY << 14) - ONE_KEY) << 40));
      // seventh code is dropped, so the report is unchanged
      send_item(load_item(SEL_BASE, 6'd54, 8'h12));
      send_item(scan_item(((ONE_KEY << 15) - ONE_KEY) << 40));
      send_item(scan_item('0));
      send_item(scan_item('0));
   endtask

   task automatic test_table_choice;
      send_item(load_item(SEL_BASE, 6'd20, 8'h04));
      send_item(load_item(SEL_SECOND, 6'd20, 8'h05));
      send_item(load_item(SEL_ALPHA, 6'd20, 8'h06));
      send_item(scan_item(ONE_KEY << 20));
      send_item(scan_item((ONE_KEY << 20) | (ONE_KEY << 5)));
      send_item(scan_item((ONE_KEY << 20) | (ONE_KEY << 15)));
      send_item(scan_item((ONE_KEY << 20) | (ONE_KEY << 15) | (ONE_KEY << 5)));
      send_item(scan_item('1));
   endtask

   // Unused entries, keys past the matrix and edge keys in the modifier map
   task automatic test_modifier_map;
      send_item(load_item(SEL_MOD, 6'd0, 8'd0));
      send_item(load_item(SEL_MOD, 6'd1, UNUSED_MOD));
      send_item(load_item(SEL_MOD, 6'd2, 8'd55));
      send_item(load_item(SEL_MOD, 6'd3, 8'd56));
      send_item(load_item(SEL_MOD, 6'd4, 8'd63));
      send_item(load_item(SEL_MOD, 6'd5, 8'hFE));
      send_item(load_item(SEL_MOD, 6'd6, 8'd15));
      send_item(load_item(SEL_MOD, 6'd7, 8'h80));
      send_item(scan_item('1));
      send_item(scan_item(ONE_KEY | (ONE_KEY << 55)));
      send_item(scan_item(ONE_KEY << 15));
   endtask

   // Loads past the end of a table must leave it untouched
   task automatic test_load_bounds;
      send_item(load_item(SEL_BASE, 6'd56, 8'h33));
      send_item(load_item(SEL_SECOND, 6'd63, 8'h34));
      send_item(load_item(SEL_ALPHA, 6'd60, 8'h35));
      send_item(load_item(SEL_MOD, 6'd8, 8'd0));
      send_item(load_item(SEL_MOD, 6'd63, 8'd0));
      send_item(scan_item('0));
      send_item(scan_item('1));
      send_item(scan_item(ONE_KEY));
   endtask

   task automatic test_key_index_regs;
      wait_idle();
      set_key_indexes(6'd0, 6'd55);
      send_item(scan_item(ONE_KEY | (ONE_KEY << 20)));
      send_item(scan_item((ONE_KEY << 55) | (ONE_KEY << 20)));
      send_item(scan_item('1));
      wait_idle();
      // indexes past the matrix never count as pressed
      set_key_indexes(6'd63, 6'd56);
      send_item(scan_item('1));
      send_item(scan_item((ONE_KEY << 15) | (ONE_KEY << 5) | (ONE_KEY << 20)));
      wait_idle();
      set_key_indexes(6'd55, 6'd0);
      send_item(scan_item(ONE_KEY | (ONE_KEY << 55)));
      send_item(scan_item(ONE_KEY | (ONE_KEY << 20)));
   endtask

   // Phases of random traffic, each under fresh key indexes and idling rates
   task automatic test_random_traffic;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         set_key_indexes(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
         if (ph == 2 || ph == RANDOM_PHASES - 1) begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end else begin
            send_gap_pct = $urandom_range(5, 40);
            stall_pct    = $urandom_range(2, 15);
         end
         repeat (PHASE_ITEMS) send_item(random_item());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_first_report();
      test_repeat_suppressed();
      test_table_choice();
      test_modifier_map();
      test_load_bounds();
      test_key_index_regs();
      test_random_traffic();
      wait_idle();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
design/khr_pkg.sv
design/khr_ram.sv
design/khr_lane.sv
design/khr_merge.sv
design/key_matrix_to_hid_report_unit.sv
test/key_matrix_to_hid_report_unit_tb.sv
